@@ hw/rtl/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants of the speech endpoint detector.
// ----------------------------------------------------------------------------
package sed_pkg;

  // request codes carried in tuser
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SIL_THRESH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIL_HOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SMP    = 3'd4;

  // configuration reset values
  localparam logic [15:0] RST_SIL_THRESH = 16'd500;
  localparam logic [15:0] RST_SIL_HOLD   = 16'd1500;
  localparam logic [15:0] RST_MAX_REC    = 16'd5000;
  localparam logic [19:0] RST_MIN_SMP    = 20'd8000;
  localparam logic [19:0] RST_MAX_SMP    = 20'd80000;

  // widths fixed by the field formats
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 20;
  localparam int unsigned RMS_W      = 16;
  localparam int unsigned SQ_W       = 31;  // mean square, at most 2^30
  localparam int unsigned SQRT_STEPS = 16;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LISTEN = 2'd1,
    PH_ENDED  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    RS_NONE    = 2'd0,
    RS_TIME    = 2'd1,
    RS_SILENCE = 2'd2,
    RS_CANCEL  = 2'd3
  } reason_e;

  typedef struct packed {
    logic accept;     // input beat taken
    logic div_step;   // one restoring divide step
    logic sqrt_init;  // load quotient into the root unit
    logic sqrt_step;  // one root step
    logic finish;     // apply silence logic with the root
    logic load;       // move result into the output register
  } sed_cmd_t;

  typedef struct packed {
    logic need_root;  // beat closes a counted chunk
    logic out_free;   // output register can take a result
  } sed_sts_t;

endpackage

@@ hw/rtl/speech_endpoint_detector_unit.sv @@
// ----------------------------------------------------------------------------
// speech_endpoint_detector_unit
// Start, cancel and non-closing sample beats: the beat is taken, then the
// result moves into the output register once that register is free.
// Counted chunk close: the one-bit-per-cycle restoring divider over the
// SUM_W-bit sum (SUM_W = 31 + clog2(CHUNK_MAX)) is followed by 16
// square-root steps. A new beat is taken while a result waits.
// Reset (async, active low): config to defaults, phase idle, recording clear.
// ----------------------------------------------------------------------------
module speech_endpoint_detector_unit #(
  parameter int unsigned CHUNK_MAX = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [47:0]                     s_axis_tdata_i,  // sample[15:0], now_ms[47:16]
  input  logic                            s_axis_tlast_i,  // chunk_end
  input  logic [1:0]                      s_axis_tuser_i,  // req_type[1:0]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // phase[1:0], end_reason[3:2], recorded_count[23:4], chunk_rms[39:24],
  // chunk_done[40], chunk_quiet[41], zero[47:42]
  output logic [47:0]                     m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sed_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int unsigned SUM_W = sed_pkg::SQ_W + $clog2(CHUNK_MAX);

  sed_pkg::sed_cmd_t cmd;
  sed_pkg::sed_sts_t sts;

  logic [1:0]                phase, reason;
  logic [sed_pkg::CNT_W-1:0] rec;
  logic [sed_pkg::RMS_W-1:0] rms;
  logic                      done, quiet;

  assign cfg_ready_o = 1'b1;

  sed_ctrl #(
    .DIV_STEPS (SUM_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sed_dp #(
    .CHUNK_MAX (CHUNK_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (s_axis_tuser_i),
    .sample_i         ($signed(s_axis_tdata_i[15:0])),
    .chunk_end_i      (s_axis_tlast_i),
    .now_ms_i         (s_axis_tdata_i[47:16]),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .phase_o          (phase),
    .end_reason_o     (reason),
    .recorded_count_o (rec),
    .chunk_rms_o      (rms),
    .chunk_done_o     (done),
    .chunk_quiet_o    (quiet)
  );

  assign m_axis_tdata_o = {6'd0, quiet, done, rms, rec, reason, phase};

  // one item in flight: no beat is taken right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while an item is still in work");

  // a result without a counted chunk carries no rms and no quiet flag
  a_no_chunk_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[40]) |->
      (m_axis_tdata_o[39:24] == '0) && !m_axis_tdata_o[41])
    else $error("chunk fields set without a counted chunk");

  // a silence end only comes from a quiet counted chunk and leaves phase ended
  a_silence_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[3:2] == sed_pkg::RS_SILENCE)) |->
      m_axis_tdata_o[40] && m_axis_tdata_o[41] &&
      (m_axis_tdata_o[1:0] == sed_pkg::PH_ENDED))
    else $error("silence end without a quiet chunk or ended phase");

endmodule

@@ hw/rtl/sed_ctrl.sv @@
// ----------------------------------------------------------------------------
// sed_ctrl
// Sequencer: takes a beat, runs divide and root steps for counted chunk
// closes, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sed_ctrl #(
  parameter int unsigned DIV_STEPS = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sed_pkg::sed_sts_t sts_i,
  output sed_pkg::sed_cmd_t cmd_o
);

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQI,
    ST_SQRT,
    ST_FIN,
    ST_POST
  } state_e;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          step_d  = '0;
          state_d = sts_i.need_root ? ST_DIV : ST_POST;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_SQI;
        end
      end
      ST_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        step_d  = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(sed_pkg::SQRT_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_POST;
      end
      ST_POST: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ hw/rtl/sed_dp.sv @@
// ----------------------------------------------------------------------------
// sed_dp
// Datapath: config registers, recording state, chunk accumulator,
// restoring divider, bit-pair square root and output register.
// ----------------------------------------------------------------------------
module sed_dp #(
  parameter int unsigned CHUNK_MAX = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sed_pkg::sed_cmd_t                   cmd_i,
  output sed_pkg::sed_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [sed_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sed_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic [1:0]                          req_type_i,
  input  logic signed [sed_pkg::SMP_W-1:0]    sample_i,
  input  logic                                chunk_end_i,
  input  logic [sed_pkg::TIME_W-1:0]          now_ms_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [1:0]                          phase_o,
  output logic [1:0]                          end_reason_o,
  output logic [sed_pkg::CNT_W-1:0]           recorded_count_o,
  output logic [sed_pkg::RMS_W-1:0]           chunk_rms_o,
  output logic                                chunk_done_o,
  output logic                                chunk_quiet_o
);

  localparam int unsigned LEN_W  = $clog2(CHUNK_MAX + 1);
  localparam int unsigned SUM_W  = sed_pkg::SQ_W + $clog2(CHUNK_MAX);
  localparam int unsigned ROOT_W = sed_pkg::SQ_W + 1;
  localparam int unsigned TW     = sed_pkg::TIME_W;
  localparam int unsigned CW     = sed_pkg::CNT_W;

  // configuration
  logic [15:0]   thresh_q, thresh_d;
  logic [15:0]   hold_q, hold_d;
  logic [15:0]   max_rec_q, max_rec_d;
  logic [CW-1:0] min_smp_q, min_smp_d;
  logic [CW-1:0] max_smp_q, max_smp_d;

  // recording state
  sed_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0]   start_q, start_d;
  logic            sil_act_q, sil_act_d;
  logic [TW-1:0]   sil_start_q, sil_start_d;
  logic [CW-1:0]   rec_q, rec_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic            out_valid_q, out_valid_d;

  // working registers
  logic [TW-1:0]        now_q;
  sed_pkg::reason_e     reason_q;
  logic [sed_pkg::RMS_W-1:0] rms_q;
  logic                 done_q, quiet_q;
  logic [SUM_W-1:0]     dvd_q;
  logic [LEN_W-1:0]     rem_q, dsr_q;
  logic [sed_pkg::SQ_W-1:0] v_q, bit_q;
  logic [ROOT_W-1:0]    root_q;

  // output register
  logic [1:0]                o_phase_q, o_reason_q;
  logic [CW-1:0]             o_rec_q;
  logic [sed_pkg::RMS_W-1:0] o_rms_q;
  logic                      o_done_q, o_quiet_q;

  // accept-time decode
  logic              listen, is_sample, over_time, closing, fits;
  logic [15:0]       mag;
  logic [31:0]       mag_sq;
  logic [SUM_W-1:0]  total;
  logic [LEN_W-1:0]  n;
  logic [CW:0]       rec_sum;
  sed_pkg::reason_e  acc_reason;

  assign listen    = (phase_q == sed_pkg::PH_LISTEN);
  assign is_sample = (req_type_i == sed_pkg::REQ_SAMPLE);
  assign over_time = (now_ms_i - start_q) > {16'd0, max_rec_q};
  assign mag       = sample_i[15] ? (~sample_i + 16'd1) : sample_i;
  assign mag_sq    = mag * mag;
  assign total     = sum_q + SUM_W'(mag_sq[sed_pkg::SQ_W-1:0]);
  assign n         = len_q + 1'b1;
  assign closing   = chunk_end_i || (n >= LEN_W'(CHUNK_MAX));
  assign rec_sum   = {1'b0, rec_q} + (CW + 1)'(n);
  assign fits      = rec_sum < {1'b0, max_smp_q};

  assign sts_o.need_root = is_sample && listen && !over_time && closing && fits;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    acc_reason = sed_pkg::RS_NONE;
    if (req_type_i == sed_pkg::REQ_CANCEL && listen) begin
      acc_reason = sed_pkg::RS_CANCEL;
    end else if (is_sample && listen && over_time) begin
      acc_reason = sed_pkg::RS_TIME;
    end
  end

  // restoring divide step
  logic [LEN_W:0]   div_sh, div_diff;
  logic             div_ge;
  assign div_sh   = {rem_q, dvd_q[SUM_W-1]};
  assign div_ge   = div_sh >= {1'b0, dsr_q};
  assign div_diff = div_sh - {1'b0, dsr_q};

  // square root step
  logic [ROOT_W-1:0] sq_trial;
  logic              sq_ge;
  assign sq_trial = root_q + ROOT_W'(bit_q);
  assign sq_ge    = {1'b0, v_q} >= sq_trial;

  // silence logic on the finished root
  logic [sed_pkg::RMS_W-1:0] rms_w;
  logic                      quiet_w, sil_end;
  assign rms_w   = root_q[sed_pkg::RMS_W-1:0];
  assign quiet_w = rms_w < thresh_q;
  assign sil_end = quiet_w && sil_act_q && ((now_q - sil_start_q) > {16'd0, hold_q})
                   && (rec_q > min_smp_q);

  always_comb begin
    thresh_d  = thresh_q;
    hold_d    = hold_q;
    max_rec_d = max_rec_q;
    min_smp_d = min_smp_q;
    max_smp_d = max_smp_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sed_pkg::CFG_SIL_THRESH: thresh_d  = cfg_data_i[15:0];
        sed_pkg::CFG_SIL_HOLD:   hold_d    = cfg_data_i[15:0];
        sed_pkg::CFG_MAX_REC:    max_rec_d = cfg_data_i[15:0];
        sed_pkg::CFG_MIN_SMP:    min_smp_d = cfg_data_i;
        sed_pkg::CFG_MAX_SMP:    max_smp_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    start_d     = start_q;
    sil_act_d   = sil_act_q;
    sil_start_d = sil_start_q;
    rec_d       = rec_q;
    sum_d       = sum_q;
    len_d       = len_q;
    if (cmd_i.accept) begin
      case (req_type_i)
        sed_pkg::REQ_START: begin
          if (!listen) begin
            rec_d = '0; sum_d = '0; len_d = '0; sil_act_d = 1'b0; sil_start_d = '0;
            start_d = now_ms_i;
            phase_d = sed_pkg::PH_LISTEN;
          end
        end
        sed_pkg::REQ_CANCEL: begin
          rec_d = '0; sum_d = '0; len_d = '0; sil_act_d = 1'b0; sil_start_d = '0;
          phase_d = sed_pkg::PH_IDLE;
        end
        sed_pkg::REQ_SAMPLE: begin
          if (listen) begin
            if (over_time) begin
              phase_d = sed_pkg::PH_ENDED;
              sum_d = '0;
              len_d = '0;
            end else if (closing) begin
              sum_d = '0;
              len_d = '0;
              if (fits) rec_d = rec_sum[CW-1:0];
            end else begin
              sum_d = total;
              len_d = n;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.finish) begin
      if (quiet_w) begin
        if (!sil_act_q) begin
          sil_act_d   = 1'b1;
          sil_start_d = now_q;
        end else if (sil_end) begin
          phase_d = sed_pkg::PH_ENDED;
        end
      end else begin
        sil_act_d   = 1'b0;
        sil_start_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= sed_pkg::RST_SIL_THRESH;
      hold_q      <= sed_pkg::RST_SIL_HOLD;
      max_rec_q   <= sed_pkg::RST_MAX_REC;
      min_smp_q   <= sed_pkg::RST_MIN_SMP;
      max_smp_q   <= sed_pkg::RST_MAX_SMP;
      phase_q     <= sed_pkg::PH_IDLE;
      start_q     <= '0;
      sil_act_q   <= 1'b0;
      sil_start_q <= '0;
      rec_q       <= '0;
      sum_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      thresh_q    <= thresh_d;
      hold_q      <= hold_d;
      max_rec_q   <= max_rec_d;
      min_smp_q   <= min_smp_d;
      max_smp_q   <= max_smp_d;
      phase_q     <= phase_d;
      start_q     <= start_d;
      sil_act_q   <= sil_act_d;
      sil_start_q <= sil_start_d;
      rec_q       <= rec_d;
      sum_q       <= sum_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q    <= now_ms_i;
      reason_q <= acc_reason;
      rms_q    <= '0;
      done_q   <= 1'b0;
      quiet_q  <= 1'b0;
      dvd_q    <= total;
      dsr_q    <= n;
      rem_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[LEN_W-1:0] : div_sh[LEN_W-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
    end
    if (cmd_i.sqrt_init) begin
      v_q    <= dvd_q[sed_pkg::SQ_W-1:0];
      root_q <= '0;
      bit_q  <= sed_pkg::SQ_W'(1) << (sed_pkg::SQ_W - 1);
    end
    if (cmd_i.sqrt_step) begin
      if (sq_ge) begin
        v_q    <= v_q - sq_trial[sed_pkg::SQ_W-1:0];
        root_q <= (root_q >> 1) + ROOT_W'(bit_q);
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.finish) begin
      rms_q    <= rms_w;
      done_q   <= 1'b1;
      quiet_q  <= quiet_w;
      reason_q <= sil_end ? sed_pkg::RS_SILENCE : sed_pkg::RS_NONE;
    end
    if (cmd_i.load) begin
      o_phase_q  <= phase_q;
      o_reason_q <= reason_q;
      o_rec_q    <= rec_q;
      o_rms_q    <= rms_q;
      o_done_q   <= done_q;
      o_quiet_q  <= quiet_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = o_phase_q;
  assign end_reason_o     = o_reason_q;
  assign recorded_count_o = o_rec_q;
  assign chunk_rms_o      = o_rms_q;
  assign chunk_done_o     = o_done_q;
  assign chunk_quiet_o    = o_quiet_q;

endmodule
